// File: src/lpi_pkg.sv
// Shared constants and types for the line pair intersection block.
package lpi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  // Operand slice width of the partial product multiplier.
  localparam int MUL_PIECE = 17;
  // Register stages in lpi_mul from operands to product.
  localparam int MUL_LAT = 4;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/line_pair_intersection_top.sv
// Top level of the line pair intersection block.
//
//   Channel  Handshake        Beat contents
//   input    push / full      two points of line A, two points of line B
//   result   empty / pop      intersection x, y, parallel flag, overflow flag
//
// One beat is accepted every cycle while full is low. A beat passes through
// the front part, the middle queue, the back part with its one-bit-per-stage
// divider, and the result queue before it reaches the result ports.
// Reset clears the pipeline valid bits and both queue pointers.
// A stalled result stalls only the back part; the front keeps filling the
// middle queue until that is full, and only then is full raised.
module line_pair_intersection_top
  import lpi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] in_a_first_x,
  input  logic [COORD_WIDTH-1:0] in_a_first_y,
  input  logic [COORD_WIDTH-1:0] in_a_second_x,
  input  logic [COORD_WIDTH-1:0] in_a_second_y,
  input  logic [COORD_WIDTH-1:0] in_b_first_x,
  input  logic [COORD_WIDTH-1:0] in_b_first_y,
  input  logic [COORD_WIDTH-1:0] in_b_second_x,
  input  logic [COORD_WIDTH-1:0] in_b_second_y,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_WIDTH-1:0] out_cross_x,
  output logic [COORD_WIDTH-1:0] out_cross_y,
  output logic                   out_parallel,
  output logic                   out_overflow
);

  localparam int W  = COORD_WIDTH;
  localparam int IW = 8 * W + 10;
  localparam int RW = 2 * W + 2;

  logic          en_f, en_b, f_vld, b_vld, b_take;
  logic [IW-1:0] f_item, mq_head;
  logic [RW-1:0] b_item, oq_head;
  q_stat_t       mq_stat, oq_stat;

  assign en_f   = !f_vld || !mq_stat.full;
  assign en_b   = !b_vld || !oq_stat.full;
  assign b_take = en_b && !mq_stat.empty;
  assign full   = !en_f;

  lpi_front #(.COORD_WIDTH(W)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en_f), .in_vld(push && en_f),
    .a1x(in_a_first_x), .a1y(in_a_first_y),
    .a2x(in_a_second_x), .a2y(in_a_second_y),
    .b1x(in_b_first_x), .b1y(in_b_first_y),
    .b2x(in_b_second_x), .b2y(in_b_second_y),
    .out_vld(f_vld), .out_item(f_item)
  );

  lpi_fifo #(.DATA_W(IW), .DEPTH(MID_DEPTH)) u_midq (
    .clk(clk), .rst_n(rst_n), .push(f_vld && en_f), .pop(b_take),
    .wdata(f_item), .rdata(mq_head), .stat(mq_stat)
  );

  lpi_back #(.COORD_WIDTH(W)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en_b), .in_vld(b_take), .in_item(mq_head),
    .res_vld(b_vld), .res_item(b_item)
  );

  lpi_fifo #(.DATA_W(RW), .DEPTH(OUT_DEPTH)) u_outq (
    .clk(clk), .rst_n(rst_n), .push(b_vld && en_b), .pop(pop),
    .wdata(b_item), .rdata(oq_head), .stat(oq_stat)
  );

  assign empty        = oq_stat.empty;
  assign out_cross_x  = oq_head[W-1:0];
  assign out_cross_y  = oq_head[2*W-1:W];
  assign out_parallel = oq_head[2*W];
  assign out_overflow = oq_head[2*W+1];

endmodule

// File: src/lpi_mul.sv
// Pipelined signed multiplier built from small unsigned partial products.
module lpi_mul
  import lpi_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic [AW+BW-1:0]     mag,
  output logic                 neg
);

  localparam int NA   = (AW + MUL_PIECE - 1) / MUL_PIECE;
  localparam int NB   = (BW + MUL_PIECE - 1) / MUL_PIECE;
  localparam int PAW  = NA * MUL_PIECE;
  localparam int PBW  = NB * MUL_PIECE;
  localparam int ROWW = MUL_PIECE + PBW;
  localparam int ACCW = PAW + PBW;

  logic [AW-1:0]            a_abs;
  logic [BW-1:0]            b_abs;
  logic [PAW-1:0]           am_r;
  logic [PBW-1:0]           bm_r;
  logic [2*MUL_PIECE-1:0]   pp_r   [0:NA-1][0:NB-1];
  logic [2*MUL_PIECE-1:0]   pp_nxt [0:NA-1][0:NB-1];
  logic [ROWW-1:0]          row_r   [0:NA-1];
  logic [ROWW-1:0]          row_nxt [0:NA-1];
  logic [ACCW-1:0]          acc;
  logic [AW+BW-1:0]         mag_r;
  logic [MUL_LAT-1:0]       neg_r;

  always_comb begin
    a_abs = a[AW-1] ? (~a + AW'(1)) : a;
    b_abs = b[BW-1] ? (~b + BW'(1)) : b;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = am_r[i*MUL_PIECE +: MUL_PIECE] * bm_r[j*MUL_PIECE +: MUL_PIECE];
      end
    end
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (ROWW'(pp_r[i][j]) << (j * MUL_PIECE));
      end
    end
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + (ACCW'(row_r[i]) << (i * MUL_PIECE));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= PAW'(a_abs);
      bm_r  <= PBW'(b_abs);
      pp_r  <= pp_nxt;
      row_r <= row_nxt;
      mag_r <= acc[AW+BW-1:0];
      neg_r <= {neg_r[MUL_LAT-2:0], a[AW-1] ^ b[BW-1]};
    end
  end

  assign mag = mag_r;
  assign neg = neg_r[MUL_LAT-1];

endmodule

// File: src/lpi_front.sv
// Front part: direction vectors, determinant and numerator, parallel classification.
module lpi_front
  import lpi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [COORD_WIDTH-1:0] a1x,
  input  logic [COORD_WIDTH-1:0] a1y,
  input  logic [COORD_WIDTH-1:0] a2x,
  input  logic [COORD_WIDTH-1:0] a2y,
  input  logic [COORD_WIDTH-1:0] b1x,
  input  logic [COORD_WIDTH-1:0] b1y,
  input  logic [COORD_WIDTH-1:0] b2x,
  input  logic [COORD_WIDTH-1:0] b2y,
  output logic                   out_vld,
  output logic [8*COORD_WIDTH+9:0] out_item
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int PW2  = 2 * DW;
  localparam int DETW = 2 * W + 3;
  localparam int FL   = MUL_LAT + 3;

  logic [FL-1:0]        vld_r;
  logic [W-1:0]         a1x_r, a1y_r;
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, cx_r, cy_r;
  logic [W-1:0]         sa1x_r [0:MUL_LAT-1];
  logic [W-1:0]         sa1y_r [0:MUL_LAT-1];
  logic [DW-1:0]        sd1x_r [0:MUL_LAT-1];
  logic [DW-1:0]        sd1y_r [0:MUL_LAT-1];
  logic [PW2-1:0]       m0, m1, m2, m3;
  logic                 n0, n1, n2, n3;
  logic [DETW-1:0]      p0, p1, p2, p3;
  logic [DETW-1:0]      det_r, num1_r, num2_r, dmag_r;
  logic [W-1:0]         a1x1_r, a1y1_r, a1x2_r, a1y2_r;
  logic [DW-1:0]        d1x1_r, d1y1_r, d1x2_r, d1y2_r;
  logic                 dneg_r, par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FL-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1x_r <= a1x;
      a1y_r <= a1y;
      d1x_r <= {a2x[W-1], a2x} - {a1x[W-1], a1x};
      d1y_r <= {a2y[W-1], a2y} - {a1y[W-1], a1y};
      d2x_r <= {b2x[W-1], b2x} - {b1x[W-1], b1x};
      d2y_r <= {b2y[W-1], b2y} - {b1y[W-1], b1y};
      cx_r  <= {b1x[W-1], b1x} - {a1x[W-1], a1x};
      cy_r  <= {b1y[W-1], b1y} - {a1y[W-1], a1y};
    end
  end

  lpi_mul #(.AW(DW), .BW(DW)) u_m0 (.clk(clk), .en(en), .a(d2x_r), .b(d1y_r), .mag(m0), .neg(n0));
  lpi_mul #(.AW(DW), .BW(DW)) u_m1 (.clk(clk), .en(en), .a(d1x_r), .b(d2y_r), .mag(m1), .neg(n1));
  lpi_mul #(.AW(DW), .BW(DW)) u_m2 (.clk(clk), .en(en), .a(d2x_r), .b(cy_r), .mag(m2), .neg(n2));
  lpi_mul #(.AW(DW), .BW(DW)) u_m3 (.clk(clk), .en(en), .a(cx_r), .b(d2y_r), .mag(m3), .neg(n3));

  always_ff @(posedge clk) begin
    if (en) begin
      sa1x_r[0] <= a1x_r;
      sa1y_r[0] <= a1y_r;
      sd1x_r[0] <= d1x_r;
      sd1y_r[0] <= d1y_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        sa1x_r[i] <= sa1x_r[i-1];
        sa1y_r[i] <= sa1y_r[i-1];
        sd1x_r[i] <= sd1x_r[i-1];
        sd1y_r[i] <= sd1y_r[i-1];
      end
    end
  end

  always_comb begin
    p0 = n0 ? (~DETW'(m0) + DETW'(1)) : DETW'(m0);
    p1 = n1 ? (~DETW'(m1) + DETW'(1)) : DETW'(m1);
    p2 = n2 ? (~DETW'(m2) + DETW'(1)) : DETW'(m2);
    p3 = n3 ? (~DETW'(m3) + DETW'(1)) : DETW'(m3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= p0 - p1;
      num1_r <= p2 - p3;
      a1x1_r <= sa1x_r[MUL_LAT-1];
      a1y1_r <= sa1y_r[MUL_LAT-1];
      d1x1_r <= sd1x_r[MUL_LAT-1];
      d1y1_r <= sd1y_r[MUL_LAT-1];
      dneg_r <= det_r[DETW-1];
      dmag_r <= det_r[DETW-1] ? (~det_r + DETW'(1)) : det_r;
      par_r  <= (det_r == '0);
      num2_r <= num1_r;
      a1x2_r <= a1x1_r;
      a1y2_r <= a1y1_r;
      d1x2_r <= d1x1_r;
      d1y2_r <= d1y1_r;
    end
  end

  assign out_vld  = vld_r[FL-1];
  assign out_item = {par_r, dneg_r, dmag_r, num2_r, d1y2_r, d1x2_r, a1y2_r, a1x2_r};

endmodule

// File: src/lpi_fifo.sv
// Small first-in first-out queue held in flip-flops.
module lpi_fifo
  import lpi_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = MID_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              pop,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata,
  output q_stat_t           stat
);

  localparam int PW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [0:DEPTH-1];
  logic [PW:0]       wr_r, rd_r;
  logic              do_push, do_pop;

  always_comb begin
    stat.empty = (wr_r == rd_r);
    stat.full  = (wr_r[PW] != rd_r[PW]) && (wr_r[PW-1:0] == rd_r[PW-1:0]);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + (PW+1)'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r[PW-1:0]] <= wdata;
    end
  end

  assign rdata = mem_r[rd_r[PW-1:0]];

endmodule

// File: src/lpi_back.sv
// Back part: scaled numerators, restoring division, rounding and saturation.
module lpi_back
  import lpi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [8*COORD_WIDTH+9:0] in_item,
  output logic                     res_vld,
  output logic [2*COORD_WIDTH+1:0] res_item
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int DETW  = 2 * W + 3;
  localparam int NMW   = DETW + DW;
  localparam int RW    = NMW + 1;
  localparam int QW    = W + 1;
  localparam int NS    = W + 2;
  localparam int SW    = W + 4;
  localparam int BL    = MUL_LAT + NS + 2;
  localparam int O_A1Y = W;
  localparam int O_D1X = 2 * W;
  localparam int O_D1Y = O_D1X + DW;
  localparam int O_NUM = O_D1Y + DW;
  localparam int O_DM  = O_NUM + DETW;
  localparam int O_DN  = O_DM + DETW;
  localparam int O_PAR = O_DN + 1;

  logic [BL-1:0]   vld_r;
  logic [W-1:0]    sa1x_r [0:MUL_LAT-1];
  logic [W-1:0]    sa1y_r [0:MUL_LAT-1];
  logic [DETW-1:0] sdm_r  [0:MUL_LAT-1];
  logic            sdn_r  [0:MUL_LAT-1];
  logic            spar_r [0:MUL_LAT-1];
  logic [NMW-1:0]  nxm, nym;
  logic            nxn, nyn;

  // Divider stage arrays: stage 0 checks for a quotient beyond range, the
  // others each settle one quotient bit from the top down.
  logic [RW-1:0]   rx_r [0:NS-1], rx_nxt [0:NS-1];
  logic [RW-1:0]   ry_r [0:NS-1], ry_nxt [0:NS-1];
  logic [QW-1:0]   qx_r [0:NS-1], qx_nxt [0:NS-1];
  logic [QW-1:0]   qy_r [0:NS-1], qy_nxt [0:NS-1];
  logic            bx_r [0:NS-1], bx_nxt [0:NS-1];
  logic            by_r [0:NS-1], by_nxt [0:NS-1];
  logic            gx_r [0:NS-1], gx_nxt [0:NS-1];
  logic            gy_r [0:NS-1], gy_nxt [0:NS-1];
  logic [DETW-1:0] dm_r [0:NS-1], dm_nxt [0:NS-1];
  logic [W-1:0]    ax_r [0:NS-1], ax_nxt [0:NS-1];
  logic [W-1:0]    ay_r [0:NS-1], ay_nxt [0:NS-1];
  logic            pa_r [0:NS-1], pa_nxt [0:NS-1];
  logic [RW-1:0]   shx, shy;

  logic [QW:0]     qrx_r, qry_r;
  logic            rgx_r, rgy_r, rbx_r, rby_r, rpa_r;
  logic [W-1:0]    rax_r, ray_r;

  logic [SW-1:0]   sumx, sumy;
  logic            satx, saty, sngx, sngy;
  logic [W-1:0]    maxv, minv, ox_nxt, oy_nxt;
  logic [W-1:0]    ox_r, oy_r;
  logic            op_r, ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BL-2:0], in_vld};
    end
  end

  lpi_mul #(.AW(DETW), .BW(DW)) u_mx (
    .clk(clk), .en(en), .a(in_item[O_NUM +: DETW]), .b(in_item[O_D1X +: DW]),
    .mag(nxm), .neg(nxn)
  );
  lpi_mul #(.AW(DETW), .BW(DW)) u_my (
    .clk(clk), .en(en), .a(in_item[O_NUM +: DETW]), .b(in_item[O_D1Y +: DW]),
    .mag(nym), .neg(nyn)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sa1x_r[0] <= in_item[0 +: W];
      sa1y_r[0] <= in_item[O_A1Y +: W];
      sdm_r[0]  <= in_item[O_DM +: DETW];
      sdn_r[0]  <= in_item[O_DN];
      spar_r[0] <= in_item[O_PAR];
      for (int i = 1; i < MUL_LAT; i++) begin
        sa1x_r[i] <= sa1x_r[i-1];
        sa1y_r[i] <= sa1y_r[i-1];
        sdm_r[i]  <= sdm_r[i-1];
        sdn_r[i]  <= sdn_r[i-1];
        spar_r[i] <= spar_r[i-1];
      end
    end
  end

  always_comb begin
    shx = '0;
    shy = '0;
    rx_nxt[0] = RW'(nxm);
    ry_nxt[0] = RW'(nym);
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    shx       = RW'(sdm_r[MUL_LAT-1]) << (NS - 1);
    bx_nxt[0] = (RW'(nxm) >= shx);
    by_nxt[0] = (RW'(nym) >= shx);
    gx_nxt[0] = nxn ^ sdn_r[MUL_LAT-1];
    gy_nxt[0] = nyn ^ sdn_r[MUL_LAT-1];
    dm_nxt[0] = sdm_r[MUL_LAT-1];
    ax_nxt[0] = sa1x_r[MUL_LAT-1];
    ay_nxt[0] = sa1y_r[MUL_LAT-1];
    pa_nxt[0] = spar_r[MUL_LAT-1];
    for (int k = 1; k < NS; k++) begin
      shx       = RW'(dm_r[k-1]) << (NS - 1 - k);
      shy       = shx;
      rx_nxt[k] = rx_r[k-1];
      ry_nxt[k] = ry_r[k-1];
      qx_nxt[k] = qx_r[k-1];
      qy_nxt[k] = qy_r[k-1];
      if (rx_r[k-1] >= shx) begin
        rx_nxt[k] = rx_r[k-1] - shx;
        qx_nxt[k] = qx_r[k-1] | (QW'(1) << (NS - 1 - k));
      end
      if (ry_r[k-1] >= shy) begin
        ry_nxt[k] = ry_r[k-1] - shy;
        qy_nxt[k] = qy_r[k-1] | (QW'(1) << (NS - 1 - k));
      end
      bx_nxt[k] = bx_r[k-1];
      by_nxt[k] = by_r[k-1];
      gx_nxt[k] = gx_r[k-1];
      gy_nxt[k] = gy_r[k-1];
      dm_nxt[k] = dm_r[k-1];
      ax_nxt[k] = ax_r[k-1];
      ay_nxt[k] = ay_r[k-1];
      pa_nxt[k] = pa_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      dm_r <= dm_nxt;
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      pa_r <= pa_nxt;
    end
  end

  // Round half away from zero on the magnitude: add one when twice the
  // remainder reaches the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      qrx_r <= (QW+1)'(qx_r[NS-1]) +
               (QW+1)'({rx_r[NS-1][DETW-1:0], 1'b0} >= {1'b0, dm_r[NS-1]});
      qry_r <= (QW+1)'(qy_r[NS-1]) +
               (QW+1)'({ry_r[NS-1][DETW-1:0], 1'b0} >= {1'b0, dm_r[NS-1]});
      rgx_r <= gx_r[NS-1];
      rgy_r <= gy_r[NS-1];
      rbx_r <= bx_r[NS-1];
      rby_r <= by_r[NS-1];
      rax_r <= ax_r[NS-1];
      ray_r <= ay_r[NS-1];
      rpa_r <= pa_r[NS-1];
    end
  end

  always_comb begin
    maxv = {1'b0, {(W-1){1'b1}}};
    minv = {1'b1, {(W-1){1'b0}}};
    sumx = rgx_r ? ({{(SW-W){rax_r[W-1]}}, rax_r} - SW'(qrx_r))
                 : ({{(SW-W){rax_r[W-1]}}, rax_r} + SW'(qrx_r));
    sumy = rgy_r ? ({{(SW-W){ray_r[W-1]}}, ray_r} - SW'(qry_r))
                 : ({{(SW-W){ray_r[W-1]}}, ray_r} + SW'(qry_r));
    satx = rbx_r || !((sumx[SW-1:W-1] == '0) || (sumx[SW-1:W-1] == '1));
    saty = rby_r || !((sumy[SW-1:W-1] == '0) || (sumy[SW-1:W-1] == '1));
    sngx = rbx_r ? rgx_r : sumx[SW-1];
    sngy = rby_r ? rgy_r : sumy[SW-1];
    ox_nxt = rpa_r ? '0 : (satx ? (sngx ? minv : maxv) : sumx[W-1:0]);
    oy_nxt = rpa_r ? '0 : (saty ? (sngy ? minv : maxv) : sumy[W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      op_r <= rpa_r;
      ov_r <= !rpa_r && (satx || saty);
    end
  end

  assign res_vld  = vld_r[BL-1];
  assign res_item = {ov_r, op_r, oy_r, ox_r};

endmodule

// File: src/lpi_checker.sv
// Port-level checks for the line pair intersection block, bound to the top level.
module lpi_checker
  import lpi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [COORD_WIDTH-1:0] out_cross_x,
  input logic [COORD_WIDTH-1:0] out_cross_y,
  input logic                   out_parallel,
  input logic                   out_overflow
);

  localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_parallel |-> out_cross_x == '0 && out_cross_y == '0 && !out_overflow)
    else $error("parallel result carries a coordinate or overflow");

  a_overflow_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_overflow |-> out_cross_x == MAXV || out_cross_x == MINV ||
                               out_cross_y == MAXV || out_cross_y == MINV)
    else $error("overflow flagged without a clamped coordinate");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_cross_x) && $stable(out_cross_y))
    else $error("waiting result changed before it was taken");

  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind line_pair_intersection_top lpi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lpi_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
  .out_parallel(out_parallel), .out_overflow(out_overflow)
);
